// ===== hdl/cbmt_pkg.sv =====
`default_nettype none
package cbmt_pkg;

	localparam int NUM_COUNTERS_DEF = 64;
	localparam int COUNT_BITS_DEF   = 16;

	localparam int CMD_W       = 2;
	localparam int IDX_W       = 6;
	localparam int VAL_OUT_W   = 16;
	localparam int NUM_OUT_W   = 7;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 40;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INC  = 2'd0,
		CMD_DEC  = 2'd1,
		CMD_CLR  = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t             op;
		logic             in_bank;
		logic [IDX_W-1:0] idx;
	} item_t;

endpackage
`default_nettype wire

// ===== hdl/counter_bank_max_tracker.sv =====
`default_nettype none
// Bank of NUM_COUNTERS saturating signed counters that tracks the largest count and how
// many counters hold it. After reset the bank is zeroed by a clearing pass over all
// NUM_COUNTERS entries, during which s_axis_tready stays low. Each beat then runs
// through the execution sequencer (read, modify/write, result), with a registered read
// of the counter memory; when the only counter at the maximum drops, a rescan of the
// whole bank is added to that beat. A two-entry queue separates command intake from
// execution, and a result register lets the next command run while a result waits.
module counter_bank_max_tracker
	import cbmt_pkg::*;
#(
	parameter int NUM_COUNTERS = NUM_COUNTERS_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// command[1:0], counter_index[7:2]
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// count_value[15:0], max_value[31:16], num_at_max[38:32], saturated[39]
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	logic  clearing;
	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  q_not_empty;
	item_t q_head;

	cbmt_front #(
		.NUM_COUNTERS (NUM_COUNTERS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.clearing      (clearing),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	cbmt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	cbmt_back #(
		.NUM_COUNTERS (NUM_COUNTERS),
		.COUNT_BITS   (COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_head        (q_head),
		.pop           (pop),
		.clearing      (clearing),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
`default_nettype wire

// ===== hdl/cbmt_front.sv =====
`default_nettype none
module cbmt_front
	import cbmt_pkg::*;
#(
	parameter int NUM_COUNTERS = NUM_COUNTERS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic                 clearing,
	input  wire logic                 q_full,
	output logic                      push,
	output item_t                     push_item
);

	logic  v_s1;
	item_t item_s1;
	item_t decoded;
	logic  take;

	always_comb begin
		decoded.op      = cmd_t'(s_axis_tdata[CMD_W-1:0]);
		decoded.idx     = s_axis_tdata[CMD_W +: IDX_W];
		decoded.in_bank = (32'(decoded.idx) < NUM_COUNTERS);
	end

	assign push          = v_s1 && !q_full;
	assign s_axis_tready = !clearing && (!v_s1 || !q_full);
	assign take          = s_axis_tvalid && s_axis_tready;
	assign push_item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= decoded;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/cbmt_queue.sv =====
`default_nettype none
module cbmt_queue
	import cbmt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       not_empty,
	output item_t      head
);

	localparam int QAW = $clog2(QUEUE_DEPTH);

	item_t          entry_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;

	assign full      = (cnt_q == (QAW+1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/cbmt_back.sv =====
`default_nettype none
module cbmt_back
	import cbmt_pkg::*;
#(
	parameter int NUM_COUNTERS = NUM_COUNTERS_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_not_empty,
	input  wire item_t                 q_head,
	output logic                       pop,
	output logic                       clearing,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	localparam int AW = $clog2(NUM_COUNTERS);
	localparam int HW = $clog2(NUM_COUNTERS + 1);
	localparam logic [AW-1:0] LAST = AW'(NUM_COUNTERS - 1);
	localparam logic signed [COUNT_BITS-1:0] CMAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic signed [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_READ   = 7'b0000100,
		ST_MODIFY = 7'b0001000,
		ST_SCAN   = 7'b0010000,
		ST_DRAIN  = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t                         state_q;
	cmd_t                           op_q;
	logic                           inb_q;
	logic [AW-1:0]                  addr_q;
	logic [AW-1:0]                  scan_q;
	logic signed [COUNT_BITS-1:0]   rdata_q;
	logic                           sd_v_q;
	logic                           sd_first_q;
	logic signed [COUNT_BITS-1:0]   largest_q;
	logic [HW-1:0]                  holders_q;
	logic signed [COUNT_BITS-1:0]   newval_q;
	logic                           sat_q;
	logic                           out_valid_q;
	logic [VAL_OUT_W-1:0]           out_count_q;
	logic [VAL_OUT_W-1:0]           out_max_q;
	logic [NUM_OUT_W-1:0]           out_num_q;
	logic                           out_sat_q;

	logic signed [COUNT_BITS-1:0]   mem [NUM_COUNTERS];

	logic signed [COUNT_BITS-1:0]   new_val;
	logic                           sat;
	logic                           changed;
	logic                           start_scan;
	logic [AW-1:0]                  rd_addr;
	logic                           we;
	logic [AW-1:0]                  wa;
	logic signed [COUNT_BITS-1:0]   wd;
	logic                           load_out;

	always_comb begin
		sat     = 1'b0;
		new_val = rdata_q;
		case (op_q)
			CMD_INC: begin
				sat = (rdata_q == CMAX);
				if (!sat) begin
					new_val = rdata_q + 1'b1;
				end
			end
			CMD_DEC: begin
				sat = (rdata_q == CMIN);
				if (!sat) begin
					new_val = rdata_q - 1'b1;
				end
			end
			CMD_CLR: begin
				new_val = '0;
			end
			default: begin
				new_val = rdata_q;
			end
		endcase
		changed    = inb_q && (new_val != rdata_q);
		start_scan = changed && !(new_val > largest_q) && (new_val != largest_q)
			&& (rdata_q == largest_q) && (holders_q == HW'(1));
	end

	always_comb begin
		rd_addr = addr_q;
		if (state_q == ST_SCAN) begin
			rd_addr = scan_q;
		end
		we = 1'b0;
		wa = addr_q;
		wd = new_val;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			wa = scan_q;
			wd = '0;
		end else if (state_q == ST_MODIFY) begin
			we = changed;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[rd_addr];
	end

	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && q_not_empty;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			scan_q      <= '0;
			sd_v_q      <= 1'b0;
			sd_first_q  <= 1'b0;
			largest_q   <= '0;
			holders_q   <= HW'(NUM_COUNTERS);
			out_valid_q <= 1'b0;
		end else begin
			sd_v_q     <= (state_q == ST_SCAN);
			sd_first_q <= (scan_q == '0);
			if (sd_v_q) begin
				if (sd_first_q || (rdata_q > largest_q)) begin
					largest_q <= rdata_q;
					holders_q <= HW'(1);
				end else if (rdata_q == largest_q) begin
					holders_q <= holders_q + 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					scan_q <= (scan_q == LAST) ? '0 : scan_q + 1'b1;
					if (scan_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_not_empty) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_MODIFY;
				end
				ST_MODIFY: begin
					if (changed && !start_scan) begin
						if (new_val > largest_q) begin
							largest_q <= new_val;
							holders_q <= HW'(1);
						end else if (new_val == largest_q) begin
							holders_q <= holders_q + 1'b1;
						end else if (rdata_q == largest_q) begin
							holders_q <= holders_q - 1'b1;
						end
					end
					state_q <= start_scan ? ST_SCAN : ST_DONE;
				end
				ST_SCAN: begin
					scan_q <= (scan_q == LAST) ? '0 : scan_q + 1'b1;
					if (scan_q == LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q   <= q_head.op;
			inb_q  <= q_head.in_bank;
			addr_q <= AW'(q_head.idx);
		end
		if (state_q == ST_MODIFY) begin
			newval_q <= inb_q ? new_val : '0;
			sat_q    <= inb_q && sat;
		end
		if (load_out) begin
			out_count_q <= VAL_OUT_W'(newval_q);
			out_max_q   <= VAL_OUT_W'(largest_q);
			out_num_q   <= NUM_OUT_W'(holders_q);
			out_sat_q   <= sat_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_sat_q, out_num_q, out_max_q, out_count_q};

endmodule
`default_nettype wire
